// ===== rtl/core/adam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_pkg
// Shared types and constants of the Adam update block (Q16.16 fixed point).
// ----------------------------------------------------------------------------
package adam_pkg;

  localparam int MAX_DIM  = 256;
  localparam int IDX_BITS = $clog2(MAX_DIM);

  // Q16.16 limits
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // register reset values
  localparam logic [15:0] RST_STEP_SIZE    = 16'd66;
  localparam logic [15:0] RST_DECAY_FIRST  = 16'd58982;
  localparam logic [15:0] RST_DECAY_SECOND = 16'd65470;
  localparam logic [15:0] RST_STABILIZER   = 16'd1;
  localparam logic [8:0]  RST_DIM          = 9'd256;

  // 1.0 in Q0.16, 17 bits wide
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  typedef enum logic [2:0] {
    REG_STEP_SIZE    = 3'd0,
    REG_DECAY_FIRST  = 3'd1,
    REG_DECAY_SECOND = 3'd2,
    REG_STABILIZER   = 3'd3,
    REG_DIM_IN_USE   = 3'd4
  } cfg_reg_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         elem_index;
    logic signed [31:0] value_in;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic               has_lower;
    logic               has_upper;
    logic               pass_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_index;
    logic signed [31:0] point_value;
    logic               was_clamped;
    logic               saturated;
    logic               pass_done;
  } out_item_t;

  // classification done by the front end
  typedef enum logic [1:0] {
    JOB_PASSIVE,
    JOB_LOAD,
    JOB_GRAD
  } job_op_t;

  typedef struct packed {
    job_op_t  op;
    logic     advance;   // gradient item marked last of pass
    in_item_t item;
  } job_t;

  // shared divide / square root unit
  typedef enum logic {
    IT_DIV,
    IT_SQRT
  } iter_op_t;

  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [47:0] num;
    logic [24:0] den;
  } it_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } it_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_WR,
    S_D1,
    S_D2,
    S_SQ,
    S_M8,
    S_M9,
    S_D3,
    S_CLAMP,
    S_OUT
  } back_state_t;

endpackage

// ===== rtl/core/adam_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/adam_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_iter
// Shared iterative unit: 48/25 bit divide (2 bits a cycle) or 48 bit
// integer square root (1 root bit a cycle). 24 steps; done is raised together with the result.
// ----------------------------------------------------------------------------
module adam_iter (
  input  logic              clk,
  input  logic              rst_n,
  input  adam_pkg::it_req_t req,
  output adam_pkg::it_rsp_t rsp
);
  import adam_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'd23;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  iter_op_t    op_r;
  logic [47:0] a_r;   // divide: dividend/quotient shifter; sqrt: remainder x
  logic [47:0] b_r;   // divide: partial remainder; sqrt: root
  logic [47:0] c_r;   // divide: divisor; sqrt: current bit

  // divide, two restoring steps
  logic [25:0] r1, r2;
  logic        ge1, ge2;
  logic [24:0] rm1, rm2;
  logic [47:0] q1, q2;

  always_comb begin
    r1  = {b_r[24:0], a_r[47]};
    ge1 = r1 >= {1'b0, c_r[24:0]};
    rm1 = ge1 ? 25'(r1 - {1'b0, c_r[24:0]}) : r1[24:0];
    q1  = {a_r[46:0], ge1};
    r2  = {rm1, q1[47]};
    ge2 = r2 >= {1'b0, c_r[24:0]};
    rm2 = ge2 ? 25'(r2 - {1'b0, c_r[24:0]}) : r2[24:0];
    q2  = {q1[46:0], ge2};
  end

  // square root, one step
  logic [47:0] s_t;
  logic        s_ge;

  always_comb begin
    s_t  = b_r + c_r;
    s_ge = a_r >= s_t;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      a_r  <= req.num;
      b_r  <= '0;
      c_r  <= (req.op == IT_DIV) ? {23'b0, req.den} : (48'h1 << 46);
    end else if (busy_r) begin
      unique case (op_r)
        IT_DIV: begin
          a_r <= q2;
          b_r <= {23'b0, rm2};
        end
        IT_SQRT: begin
          a_r <= s_ge ? (a_r - s_t) : a_r;
          b_r <= s_ge ? ((b_r >> 1) + c_r) : (b_r >> 1);
          c_r <= c_r >> 2;
        end
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == IT_DIV) ? a_r : b_r;

endmodule

// ===== rtl/core/adam_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_front
// Input side: accepts items, classifies them and queues them (2 deep).
// ----------------------------------------------------------------------------
module adam_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  adam_pkg::in_item_t in_data,
  input  logic [8:0]         dim_in_use,
  output logic               job_valid,
  output adam_pkg::job_t     job,
  input  logic               job_pop
);
  import adam_pkg::*;

  job_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  job_t       job_new;

  // classify
  always_comb begin
    job_new.item    = in_data;
    job_new.advance = (in_data.kind == KIND_GRAD) && in_data.pass_end;
    if ({1'b0, in_data.elem_index} >= dim_in_use) begin
      job_new.op = JOB_PASSIVE;
    end else if (in_data.kind == KIND_GRAD) begin
      job_new.op = JOB_GRAD;
    end else begin
      job_new.op = JOB_LOAD;
    end
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign job_valid = (count_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (job_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, job_pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= job_new;
    end
  end

endmodule

// ===== rtl/core/adam_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_back
// Execution side: configuration, moment/point stores, multiply sequencer,
// bias correction through the shared divide/sqrt unit, clamping, output reg.
// ----------------------------------------------------------------------------
module adam_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output logic [8:0]          dim_in_use,
  input  logic                job_valid,
  input  adam_pkg::job_t      job,
  output logic                job_pop,
  output adam_pkg::it_req_t   it_req,
  input  adam_pkg::it_rsp_t   it_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output adam_pkg::out_item_t out_data
);
  import adam_pkg::*;

  // configuration and running powers
  logic [15:0] step_size_r, decay_first_r, decay_second_r, stab_r;
  logic [8:0]  dim_r;
  logic [15:0] pow1_r, pow2_r;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic        sf_r, cl_r;
  logic signed [31:0] x_r;
  logic signed [31:0] m_r;
  logic [31:0] v_r;
  logic [46:0] g2_r;
  logic signed [65:0] acc_r, prod_r;
  logic        mneg_r;
  logic [31:0] mag_r;
  logic [24:0] den_r;
  logic [MAX_DIM-1:0] mvalid_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        out_free;
  logic        mom_we, pt_we, rd_en;
  logic [IDX_BITS-1:0] rd_addr, wr_addr;
  logic [31:0] m_rdata, v_rdata, pt_rdata;

  assign cfg_ready  = 1'b1;
  assign dim_in_use = dim_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign rd_addr    = job.item.elem_index;
  assign wr_addr    = job_r.item.elem_index;

  // stores
  adam_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_first (
    .clk(clk), .we(mom_we), .waddr(wr_addr), .wdata(m_r),
    .re(rd_en), .raddr(rd_addr), .rdata(m_rdata)
  );
  adam_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_second (
    .clk(clk), .we(mom_we), .waddr(wr_addr), .wdata(v_r),
    .re(rd_en), .raddr(rd_addr), .rdata(v_rdata)
  );
  adam_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_point (
    .clk(clk), .we(pt_we), .waddr(wr_addr), .wdata(x_r),
    .re(rd_en), .raddr(rd_addr), .rdata(pt_rdata)
  );

  // operand helpers
  logic signed [31:0] g;
  logic [31:0]        ag;
  logic [16:0]        c1, c2, d1, d2;

  always_comb begin
    g  = job_r.item.value_in;
    ag = g[31] ? (~g + 32'd1) : g;
    c1 = ONE_Q16 - {1'b0, decay_first_r};
    c2 = ONE_Q16 - {1'b0, decay_second_r};
    d1 = ONE_Q16 - {1'b0, pow1_r};
    d2 = ONE_Q16 - {1'b0, pow2_r};
  end

  // shared multiplier, registered product
  logic signed [32:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M1: begin
        mul_a = {17'b0, decay_first_r};
        mul_b = {m_r[31], m_r};
      end
      S_M2: begin
        mul_a = {16'b0, c1};
        mul_b = {g[31], g};
      end
      S_M3: begin
        mul_a = {1'b0, ag};
        mul_b = {1'b0, ag};
      end
      S_M4: begin
        mul_a = {17'b0, decay_second_r};
        mul_b = {1'b0, v_r};
      end
      S_M5: begin
        mul_a = {16'b0, c2};
        mul_b = {9'b0, g2_r[23:0]};
      end
      S_M6: begin
        mul_a = {16'b0, c2};
        mul_b = {10'b0, g2_r[46:24]};
      end
      S_M8: begin
        mul_a = {17'b0, step_size_r};
        mul_b = {1'b0, mag_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // first moment: floor shift and saturate
  logic signed [65:0] msum, mfl;
  logic               m_ovf;
  logic signed [31:0] m_sat;
  // second moment
  logic [65:0]        vnum;
  logic [49:0]        vs;
  logic [31:0]        v_sat;
  logic               v_ovf;

  always_comb begin
    msum  = acc_r + prod_r;
    mfl   = msum >>> 16;
    m_ovf = !((&mfl[65:31]) || (~|mfl[65:31]));
    m_sat = m_ovf ? (mfl[65] ? VAL_MIN : VAL_MAX) : mfl[31:0];
    vnum  = 66'(acc_r + (prod_r <<< 24));
    vs    = vnum[65:16];
    v_ovf = |vs[49:31];
    v_sat = v_ovf ? 32'h7FFF_FFFF : {1'b0, vs[30:0]};
  end

  // bias correction results
  logic [47:0] q;
  logic        mh_ovf;
  logic [31:0] mh_mag;
  logic        vh_ovf;
  logic [30:0] vh;
  logic [24:0] dsum;
  logic        st_ovf;
  logic [30:0] step;
  logic signed [33:0] xs;
  logic        x_ovf;
  logic signed [31:0] x_upd;

  always_comb begin
    q = it_rsp.result;
    if (m_r[31]) begin
      mh_ovf = (|q[47:32]) || (q[31] && (|q[30:0]));
      mh_mag = mh_ovf ? 32'h8000_0000 : q[31:0];
    end else begin
      mh_ovf = |q[47:31];
      mh_mag = mh_ovf ? 32'h7FFF_FFFF : q[31:0];
    end
    vh_ovf = |q[47:31];
    vh     = vh_ovf ? 31'h7FFF_FFFF : q[30:0];
    dsum   = {1'b0, q[23:0]} + {9'b0, stab_r};
    st_ovf = |q[47:31];
    step   = st_ovf ? 31'h7FFF_FFFF : q[30:0];
    xs     = mneg_r ? ({{2{x_r[31]}}, x_r} + {3'b0, step})
                    : ({{2{x_r[31]}}, x_r} - {3'b0, step});
    x_ovf  = !((&xs[33:31]) || (~|xs[33:31]));
    x_upd  = x_ovf ? (xs[33] ? VAL_MIN : VAL_MAX) : xs[31:0];
  end

  // clamp, lower bound first
  logic signed [31:0] x_lo, x_cl;
  logic               hit_lo, hit_hi;

  always_comb begin
    hit_lo = job_r.item.has_lower && (x_r < job_r.item.lower_limit);
    x_lo   = hit_lo ? job_r.item.lower_limit : x_r;
    hit_hi = job_r.item.has_upper && (x_lo > job_r.item.upper_limit);
    x_cl   = hit_hi ? job_r.item.upper_limit : x_lo;
  end

  // sequencer: next state and control outputs
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    rd_en     = 1'b0;
    mom_we    = 1'b0;
    pt_we     = 1'b0;
    it_req    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          rd_en     = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        unique case (job_r.op)
          JOB_PASSIVE: state_nxt = S_OUT;
          JOB_LOAD:    state_nxt = S_CLAMP;
          JOB_GRAD:    state_nxt = S_M1;
          default:     state_nxt = S_OUT;
        endcase
      end
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_M3;
      S_M3: state_nxt = S_M4;
      S_M4: state_nxt = S_M5;
      S_M5: state_nxt = S_M6;
      S_M6: state_nxt = S_M7;
      S_M7: state_nxt = S_WR;
      S_WR: begin
        mom_we     = 1'b1;
        it_req.start = 1'b1;
        it_req.op  = IT_DIV;
        it_req.num = {(m_r[31] ? (~m_r + 32'd1) : m_r), 16'b0};
        it_req.den = {8'b0, d1};
        state_nxt  = S_D1;
      end
      S_D1: begin
        if (it_rsp.done) begin
          it_req.start = 1'b1;
          it_req.op  = IT_DIV;
          it_req.num = {v_r, 16'b0};
          it_req.den = {8'b0, d2};
          state_nxt  = S_D2;
        end
      end
      S_D2: begin
        if (it_rsp.done) begin
          it_req.start = 1'b1;
          it_req.op  = IT_SQRT;
          it_req.num = {1'b0, vh, 16'b0};
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        if (it_rsp.done) begin
          state_nxt = S_M8;
        end
      end
      S_M8: state_nxt = S_M9;
      S_M9: begin
        it_req.start = 1'b1;
        it_req.op  = IT_DIV;
        it_req.num = prod_r[47:0];
        it_req.den = den_r;
        state_nxt  = S_D3;
      end
      S_D3: begin
        if (it_rsp.done) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          if (job_r.op != JOB_PASSIVE) begin
            pt_we = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_r <= job;
          sf_r  <= 1'b0;
          cl_r  <= 1'b0;
        end
      end
      S_READ: begin
        m_r <= mvalid_r[job_r.item.elem_index] ? m_rdata : '0;
        v_r <= mvalid_r[job_r.item.elem_index] ? v_rdata : '0;
        x_r <= (job_r.op == JOB_LOAD) ? job_r.item.value_in : pt_rdata;
      end
      S_M2: acc_r <= prod_r;
      S_M3: begin
        m_r  <= m_sat;
        sf_r <= sf_r | m_ovf;
      end
      S_M4: g2_r <= prod_r[62:16];
      S_M5: acc_r <= prod_r;
      S_M6: acc_r <= acc_r + prod_r;
      S_M7: begin
        v_r  <= v_sat;
        sf_r <= sf_r | v_ovf;
      end
      S_D1: begin
        if (it_rsp.done) begin
          mag_r  <= mh_mag;
          mneg_r <= m_r[31] && (q != '0);
          sf_r   <= sf_r | mh_ovf;
        end
      end
      S_D2: begin
        if (it_rsp.done) begin
          sf_r <= sf_r | vh_ovf;
        end
      end
      S_SQ: begin
        if (it_rsp.done) begin
          den_r <= (dsum == '0) ? 25'd1 : dsum;
        end
      end
      S_D3: begin
        if (it_rsp.done) begin
          x_r  <= x_upd;
          sf_r <= sf_r | st_ovf | x_ovf;
        end
      end
      S_CLAMP: begin
        x_r  <= x_cl;
        cl_r <= hit_lo || hit_hi;
      end
      default: begin
      end
    endcase
  end

  // moment valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r <= '0;
    end else if (mom_we) begin
      mvalid_r[wr_addr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_r.out_index   <= job_r.item.elem_index;
      out_r.point_value <= x_r;
      out_r.was_clamped <= cl_r;
      out_r.saturated   <= sf_r;
      out_r.pass_done   <= job_r.item.pass_end;
    end
  end

  // configuration registers and running powers
  logic [31:0] pow1_prod, pow2_prod;

  assign pow1_prod = pow1_r * decay_first_r;
  assign pow2_prod = pow2_r * decay_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r     <= RST_STEP_SIZE;
      decay_first_r   <= RST_DECAY_FIRST;
      decay_second_r  <= RST_DECAY_SECOND;
      stab_r          <= RST_STABILIZER;
      dim_r           <= RST_DIM;
      pow1_r          <= RST_DECAY_FIRST;
      pow2_r          <= RST_DECAY_SECOND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_SIZE: step_size_r <= cfg_wdata;
        REG_DECAY_FIRST: begin
          decay_first_r <= cfg_wdata;
          pow1_r        <= cfg_wdata;
        end
        REG_DECAY_SECOND: begin
          decay_second_r <= cfg_wdata;
          pow2_r         <= cfg_wdata;
        end
        REG_STABILIZER: stab_r <= cfg_wdata;
        REG_DIM_IN_USE: dim_r  <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end else if (state_r == S_OUT && out_free && job_r.advance) begin
      pow1_r <= pow1_prod[31:16];
      pow2_r <= pow2_prod[31:16];
    end
  end

endmodule

// ===== rtl/core/adam_optimizer_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_optimizer_step
// Per-element Adam parameter update in Q16.16 with saturation and bounds.
// ----------------------------------------------------------------------------
// Items enter a two-deep queue and are worked one at a time. A gradient item
// runs the store read, the multiplier steps and the moment write, then three
// 48-bit divisions and one square root on the shared iterative unit, then
// clamping and the output transfer. A load item takes value_in, is clamped
// and output; an item indexed at or beyond dimension_in_use goes straight
// to the output, waiting while the output stalls. One result per item, in
// order. Moments of elements never updated read as zero; points are defined
// once loaded. Write configuration only while idle; this is not enforced.
module adam_optimizer_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  adam_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output adam_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import adam_pkg::*;

  logic       job_valid;
  job_t       job;
  logic       job_pop;
  logic [8:0] dim_in_use;
  it_req_t    it_req;
  it_rsp_t    it_rsp;

  adam_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .dim_in_use(dim_in_use),
    .job_valid(job_valid), .job(job), .job_pop(job_pop)
  );

  adam_iter u_iter (
    .clk(clk), .rst_n(rst_n), .req(it_req), .rsp(it_rsp)
  );

  adam_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .dim_in_use(dim_in_use),
    .job_valid(job_valid), .job(job), .job_pop(job_pop),
    .it_req(it_req), .it_rsp(it_rsp),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
